### hdl/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is held off while reset is asserted.
`define PUD_ASSERT(label, clock, rstn, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);

// Check that is also evaluated during reset.
`define PUD_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/pud_pkg.sv
`default_nettype none

package pud_pkg;

  // Characters that the decoder treats specially.
  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Configuration register map.
  localparam int         CFG_AW    = 3;
  localparam logic       REG_LIMIT = 1'b0;
  localparam logic [15:0] LIMIT_RST = 16'd256;

  // Default depth of the run queue between front and back.
  localparam int QDEPTH_DEF = 4;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       term;
  } res_t;

  // All results caused by one input item, oldest in slot 0.
  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] cnt;
  } run_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Value of a hex digit; only called on characters that pass is_hex.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h61) t = c - 8'h57;
    else if (c >= 8'h41) t = c - 8'h37;
    else t = c - 8'h30;
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

### hdl/pud_in_if.sv
`default_nettype none

interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

### hdl/pud_out_if.sv
`default_nettype none

interface pud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_terminator,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input is_terminator,
                input last_of_run, output ready);
endinterface

`default_nettype wire

### hdl/pud_front.sv
`default_nettype none

module pud_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pud_in_if.sink             in_ch,
  input  wire logic [15:0]   limit,
  input  wire logic          q_full,
  output logic               push,
  output pud_pkg::run_t      run
);
  import pud_pkg::*;

  typedef enum logic [1:0] {PH_NONE, PH_PCT, PH_DIGIT} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] bw_r, bw_nxt;

  logic             accept;
  logic [7:0]       c;
  logic             pc_pct;
  logic [7:0]       pc_byte;
  logic [2:0][7:0]  d;
  logic [1:0]       n;
  logic             term;
  logic [15:0]      cap;
  logic [15:0]      rem;
  logic [1:0]       keep;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;

  // How the incoming byte reads when it is taken as plain input.
  assign pc_pct  = (c == PCT_CHAR);
  assign pc_byte = (c == PLUS_CHAR) ? SPACE_CHAR : c;

  // Escape sequencing: candidate data bytes for this item, before the cap.
  always_comb begin
    d         = '0;
    n         = 2'd0;
    term      = 1'b0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (in_ch.end_of_string) begin
      term      = 1'b1;
      phase_nxt = PH_NONE;
      held_nxt  = 8'h00;
      case (phase_r)
        PH_PCT: begin
          d[0] = PCT_CHAR;
          n    = 2'd1;
        end
        PH_DIGIT: begin
          d[0] = PCT_CHAR;
          d[1] = held_r;
          n    = 2'd2;
        end
        default: n = 2'd0;
      endcase
    end else begin
      case (phase_r)
        PH_PCT: begin
          if (is_hex(c)) begin
            held_nxt  = c;
            phase_nxt = PH_DIGIT;
          end else begin
            phase_nxt = PH_NONE;
            d[0]      = PCT_CHAR;
            if (pc_pct) begin
              phase_nxt = PH_PCT;
              n         = 2'd1;
            end else begin
              d[1] = pc_byte;
              n    = 2'd2;
            end
          end
        end
        PH_DIGIT: begin
          phase_nxt = PH_NONE;
          held_nxt  = 8'h00;
          if (is_hex(c)) begin
            d[0] = {hex_val(held_r), hex_val(c)};
            n    = 2'd1;
          end else begin
            d[0] = PCT_CHAR;
            d[1] = held_r;
            if (pc_pct) begin
              phase_nxt = PH_PCT;
              n         = 2'd2;
            end else begin
              d[2] = pc_byte;
              n    = 2'd3;
            end
          end
        end
        default: begin
          phase_nxt = PH_NONE;
          if (pc_pct) begin
            phase_nxt = PH_PCT;
          end else begin
            d[0] = pc_byte;
            n    = 2'd1;
          end
        end
      endcase
    end
  end

  // Capacity: keep only as many data bytes as the string still has room for.
  assign cap  = (limit == 16'd0) ? 16'd0 : limit - 16'd1;
  assign rem  = (cap > bw_r) ? cap - bw_r : 16'd0;
  assign keep = (rem >= {14'd0, n}) ? n : rem[1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      run.res[i].data = d[i];
      run.res[i].term = 1'b0;
    end
    if (term) begin
      run.res[keep].data = 8'h00;
      run.res[keep].term = 1'b1;
    end
    run.cnt = keep + {1'b0, term};
  end

  assign push   = accept && (run.cnt != 2'd0);
  assign bw_nxt = in_ch.end_of_string ? 16'd0 : bw_r + {14'd0, keep};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      held_r  <= 8'h00;
      bw_r    <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      bw_r    <= bw_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/pud_queue.sv
`default_nettype none

module pud_queue #(
  parameter int DEPTH = pud_pkg::QDEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pud_pkg::run_t push_run,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output pud_pkg::run_t      head
);
  import pud_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t            mem [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointers wrap at the depth, which need not be a power of two.
  assign wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
  assign rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_nxt;
      if (do_pop) rd_r <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/pud_back.sv
`default_nettype none

module pud_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire pud_pkg::run_t head,
  output logic               pop,
  pud_out_if.source          out_ch
);
  import pud_pkg::*;

  logic [1:0] pos_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_term_r;
  logic       out_last_r;
  logic       load;
  logic       last;
  res_t       cur;

  // With a run queued, the output register refills when empty or taken.
  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign cur  = head.res[pos_r];
  assign last = (pos_r == head.cnt - 2'd1);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        pos_r       <= last ? 2'd0 : pos_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur.data;
      out_term_r <= cur.term;
      out_last_r <= last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.is_terminator = out_term_r;
  assign out_ch.last_of_run   = out_last_r;

endmodule

`default_nettype wire

### hdl/percent_url_decoder.sv
// Streaming URL percent-decoder with '+' taken as a space.
// Input channel in_ch carries one encoded byte per item, or an end item
// (end_of_string set) that flushes held escape bytes and yields a terminator.
// Output channel out_ch carries one decoded byte per item; last_of_run marks
// the final result caused by an input item. An input item gives zero to three
// results; items that give none (a held '%' or hex digit) produce no output.
// The APB-style cfg_ port holds output_limit at address 0; write it only
// while the block is idle. At most output_limit-1 data bytes leave per string.
// Each result is held in the run queue and then in the output register. The
// front classifies one item per cycle into a queue of runs while the queue
// has room; the back drains one result per cycle into the output register
// while the receiver takes them, so the block sustains one item per cycle
// when each item gives one result and the receiver does not stall; an item
// with several results stays in the queue until the back has sent each of
// them. in_ch.ready drops only when the run queue is full. When the receiver
// stalls, the output item holds and the queue fills behind it. Reset empties
// the queue and the output register, clears the escape state and the byte
// count, and sets output_limit to 256.
`default_nettype none

module percent_url_decoder #(
  parameter int QUEUE_DEPTH = pud_pkg::QDEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  pud_in_if.sink                            in_ch,
  pud_out_if.source                         out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [pud_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import pud_pkg::*;

  `include "assert_macros.svh"

  logic [15:0] limit_r;
  logic        cfg_wr;
  logic        q_full;
  logic        push;
  run_t        push_run;
  logic        head_valid;
  run_t        head;
  logic        pop;
  logic        out_term;
  logic        term_ok;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_AW-1] == REG_LIMIT);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_LIMIT) ? {16'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr) begin
      limit_r <= cfg_pwdata[15:0];
    end
  end

  pud_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .limit  (limit_r),
    .q_full (q_full),
    .push   (push),
    .run    (push_run)
  );

  pud_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_run   (push_run),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pud_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // Terminator seen on the output, and whether it is shaped as it should be.
  assign out_term = out_ch.valid && out_ch.is_terminator;
  assign term_ok  = out_ch.last_of_run && (out_ch.out_byte == 8'h00);

  // A run entering the queue always holds at least one result.
  `PUD_ASSERT(a_push_nonempty, clk, rst_n, push |-> (push_run.cnt != 2'd0), "empty run pushed")
  // The terminator closes its run and carries a zero byte.
  `PUD_ASSERT(a_term_last, clk, rst_n, out_term |-> term_ok, "terminator not last or not zero")
  // The back only pops a run that is present.
  `PUD_ASSERT(a_pop_valid, clk, rst_n, pop |-> head_valid, "pop from empty queue")
  // No result is offered right after a reset cycle.
  `PUD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_ch.valid, "output valid after reset")

endmodule

`default_nettype wire
